FILE: hw/rtl/cmc_pkg.sv
package cmc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W = 32;
	localparam int ACC_W = 2 * WORD_W + 2;
	localparam int NUM_VALUES = 10;
	localparam int IDX_W = $clog2(NUM_VALUES);
	localparam int CNT_W = 5;

	localparam int IN_DATA_W = ((NUM_VALUES * WORD_W + 7) / 8) * 8;
	localparam int IN_USER_W = 2;
	localparam int OUT_FIELDS_W = 4 * WORD_W + 4;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int CFG_INDEX_W = 8;

	localparam int TU_MODE = 0;
	localparam int TU_OK = 1;

	localparam logic [63:0] PI_Q48 = 64'h0003_243F_6A88_85A3;
	localparam logic [63:0] ROUND_HALF = 64'd1 << (47 - FRAC_BITS);
	localparam logic [63:0] PI_WIDE = (PI_Q48 + ROUND_HALF) >> (48 - FRAC_BITS);
	localparam logic [63:0] TWO_PI_WIDE = ((PI_Q48 << 1) + ROUND_HALF) >> (48 - FRAC_BITS);
	localparam logic [WORD_W-1:0] PI_FX = PI_WIDE[WORD_W-1:0];
	localparam logic [WORD_W-1:0] TWO_PI_FX = TWO_PI_WIDE[WORD_W-1:0];

	localparam int TWO_PI_BITS = $clog2(TWO_PI_WIDE + 64'd1);
	localparam int MOD_SHIFT = WORD_W - TWO_PI_BITS;
	localparam int MOD_STEPS = MOD_SHIFT + 1;
	localparam int DIV_W = WORD_W + 1;
	localparam logic [63:0] DIV_START_WIDE = TWO_PI_WIDE << MOD_SHIFT;
	localparam logic [DIV_W-1:0] DIV_START = DIV_START_WIDE[DIV_W-1:0];

	localparam logic [CFG_INDEX_W-1:0] CFG_STATIC_THRESHOLD = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_CUT_POSITION = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] CFG_CUT_ANGLE = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] CFG_CUT_PROJECTION = CFG_INDEX_W'(3);

	localparam logic [WORD_W-1:0] RST_STATIC_THRESHOLD = WORD_W'(0);
	localparam logic [WORD_W-1:0] RST_CUT_POSITION = WORD_W'(49152);
	localparam logic [WORD_W-1:0] RST_CUT_ANGLE = WORD_W'(22938);
	localparam logic [WORD_W-1:0] RST_CUT_PROJECTION = WORD_W'(13107);

	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
		logic sub;
	} alu_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic neg;
	} alu_rsp_t;

endpackage

FILE: hw/rtl/cmc_addsub.sv
module cmc_addsub (
	input  cmc_pkg::alu_req_t req,
	output cmc_pkg::alu_rsp_t rsp
);
	import cmc_pkg::*;

	logic [ACC_W-1:0] b_eff;
	logic [ACC_W-1:0] sum;

	assign b_eff = req.sub ? ~req.b : req.b;
	assign sum = req.a + b_eff + {{(ACC_W-1){1'b0}}, req.sub};
	assign rsp.sum = sum;
	assign rsp.neg = sum[ACC_W-1];

endmodule

FILE: hw/rtl/camera_motion_classifier.sv
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: ten Q16.16 camera values, tuser: mode, ok
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: deltas and flags, tuser: ok
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A camera with a measurement occupies the block until its result goes to the output register;
// one 66-bit adder/subtractor does every step: ten differences, the sum of squares, a 32-step
// square root, two modulo reductions of 14 steps each and seven comparisons for the maxima.
// A camera without a measurement goes straight to S_DONE. cfg_ready is always high.
// Asynchronous reset clears state, previous camera mark and output register, sets cfg defaults.
// A finished result waits for the output register to empty; the input stays stalled meanwhile.
module camera_motion_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// position_x, position_y, position_z, yaw_angle, pitch_angle, roll_angle,
	// near_distance, far_distance, aspect, active_extent
	input  logic [cmc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// mode_ortho, camera_ok
	input  logic [cmc_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// move_delta, turn_delta, lens_delta, mode_changed, largest_delta,
	// is_static, is_moving, is_cut, zero padding
	output logic [cmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// ok
	output logic                              m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cmc_pkg::WORD_W-1:0]        cfg_data
);
	import cmc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DIFF, S_SQ, S_SQRT, S_MOD, S_FOLD, S_MAX, S_DONE
	} state_t;

	localparam logic [IDX_W-1:0] IX_POS_Z = IDX_W'(2);
	localparam logic [IDX_W-1:0] IX_YAW = IDX_W'(3);
	localparam logic [IDX_W-1:0] IX_PITCH = IDX_W'(4);
	localparam logic [IDX_W-1:0] IX_ROLL = IDX_W'(5);
	localparam logic [IDX_W-1:0] IX_NEAR = IDX_W'(6);
	localparam logic [IDX_W-1:0] IX_FAR = IDX_W'(7);
	localparam logic [IDX_W-1:0] IX_ASPECT = IDX_W'(8);
	localparam logic [IDX_W-1:0] IX_EXTENT = IDX_W'(9);

	localparam logic [CNT_W-1:0] MX_YAW = CNT_W'(0);
	localparam logic [CNT_W-1:0] MX_PITCH = CNT_W'(1);
	localparam logic [CNT_W-1:0] MX_ROLL = CNT_W'(2);
	localparam logic [CNT_W-1:0] MX_NEAR = CNT_W'(3);
	localparam logic [CNT_W-1:0] MX_FAR = CNT_W'(4);
	localparam logic [CNT_W-1:0] MX_ASPECT = CNT_W'(5);
	localparam logic [CNT_W-1:0] MX_EXTENT = CNT_W'(6);
	localparam logic [CNT_W-1:0] MX_MOVE = CNT_W'(7);
	localparam logic [CNT_W-1:0] MX_TURN = CNT_W'(8);
	localparam logic [CNT_W-1:0] MX_LENS = CNT_W'(9);

	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(WORD_W - 1);
	localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_STEPS - 1);
	localparam logic [2*WORD_W-2:0] SQRT_BIT_START = {1'b1, {(2*WORD_W-2){1'b0}}};
	localparam int PAD_W = ACC_W - WORD_W;

	state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic prev_valid_q;
	logic prev_mode_q;
	logic m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic m_tuser_q;

	logic [WORD_W-1:0] static_threshold_q;
	logic [WORD_W-1:0] cut_position_q;
	logic [WORD_W-1:0] cut_angle_q;
	logic [WORD_W-1:0] cut_projection_q;

	logic [WORD_W-1:0] in_q [NUM_VALUES];
	logic in_mode_q;
	logic in_ok_q;
	logic [WORD_W-1:0] prev_q [NUM_VALUES];
	logic [WORD_W-1:0] diff_q [NUM_VALUES];
	logic [ACC_W-1:0] acc_q;
	logic [2*WORD_W-1:0] res_q;
	logic [2*WORD_W-2:0] bit_q;
	logic [DIV_W-1:0] div_q;
	logic [2*WORD_W-1:0] prod_s1;
	logic sat_q;
	logic [WORD_W-1:0] run_q;
	logic [WORD_W-1:0] move_q;
	logic [WORD_W-1:0] turn_q;
	logic [WORD_W-1:0] lens_q;
	logic [WORD_W-1:0] largest_q;
	logic mc_q;
	logic ok_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic in_fire;
	logic measure;
	logic slot_free;
	logic fold_leave;
	logic [WORD_W-1:0] sq_in;
	logic [2*WORD_W-1:0] res_shift;
	logic [2*WORD_W-1:0] res_nxt;
	logic [WORD_W-1:0] max_src;
	logic max_load;
	logic max_skip;
	logic [WORD_W-1:0] run_nxt;
	logic is_static;
	logic is_moving;
	logic is_cut;

	cmc_addsub u_addsub (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign measure = prev_valid_q && s_axis_tuser[TU_OK];
	assign slot_free = !m_tvalid_q || m_axis_tready;
	assign fold_leave = phase_q || !alu_rsp.neg;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata = m_tdata_q;
	assign m_axis_tuser = m_tuser_q;

	assign sq_in = diff_q[idx_q];
	assign res_shift = res_q >> 1;
	assign res_nxt = alu_rsp.neg ? res_shift : (res_shift | {1'b0, bit_q});

	always_comb begin
		max_src = diff_q[IX_YAW];
		case (cnt_q)
			MX_YAW:    max_src = diff_q[IX_YAW];
			MX_PITCH:  max_src = diff_q[IX_PITCH];
			MX_ROLL:   max_src = diff_q[IX_ROLL];
			MX_NEAR:   max_src = diff_q[IX_NEAR];
			MX_FAR:    max_src = diff_q[IX_FAR];
			MX_ASPECT: max_src = diff_q[IX_ASPECT];
			MX_EXTENT: max_src = diff_q[IX_EXTENT];
			MX_MOVE:   max_src = move_q;
			MX_TURN:   max_src = turn_q;
			MX_LENS:   max_src = lens_q;
			default:   max_src = diff_q[IX_YAW];
		endcase
	end

	assign max_load = (cnt_q == MX_YAW) || (cnt_q == MX_NEAR) || (cnt_q == MX_MOVE);
	assign max_skip = (cnt_q == MX_EXTENT) && (in_mode_q != prev_mode_q);

	always_comb begin
		if (max_load) begin
			run_nxt = max_src;
		end else if (max_skip || !alu_rsp.neg) begin
			run_nxt = run_q;
		end else begin
			run_nxt = max_src;
		end
	end

	always_comb begin
		alu_req = '0;
		case (state_q)
			S_DIFF: begin
				if (!phase_q) begin
					alu_req.a = {{PAD_W{in_q[idx_q][WORD_W-1]}}, in_q[idx_q]};
					alu_req.b = {{PAD_W{prev_q[idx_q][WORD_W-1]}}, prev_q[idx_q]};
					alu_req.sub = 1'b1;
				end else if (acc_q[ACC_W-1]) begin
					alu_req.b = acc_q;
					alu_req.sub = 1'b1;
				end else begin
					alu_req.a = acc_q;
				end
			end
			S_SQ: begin
				alu_req.a = acc_q;
				alu_req.b = {2'b00, prod_s1};
			end
			S_SQRT: begin
				alu_req.a = acc_q;
				alu_req.b = {2'b00, res_q | {1'b0, bit_q}};
				alu_req.sub = 1'b1;
			end
			S_MOD: begin
				alu_req.a = acc_q;
				alu_req.b = {{(ACC_W-DIV_W){1'b0}}, div_q};
				alu_req.sub = 1'b1;
			end
			S_FOLD: begin
				alu_req.a = phase_q ? {{PAD_W{1'b0}}, TWO_PI_FX} : {{PAD_W{1'b0}}, PI_FX};
				alu_req.b = acc_q;
				alu_req.sub = 1'b1;
			end
			S_MAX: begin
				alu_req.a = {{PAD_W{1'b0}}, run_q};
				alu_req.b = {{PAD_W{1'b0}}, max_src};
				alu_req.sub = 1'b1;
			end
			default: alu_req = '0;
		endcase
	end

	assign is_static = !mc_q && (move_q <= static_threshold_q) && (turn_q <= static_threshold_q)
		&& (lens_q <= static_threshold_q);
	assign is_moving = (move_q > static_threshold_q) || (turn_q > static_threshold_q);
	assign is_cut = mc_q || (move_q > cut_position_q) || (turn_q > cut_angle_q)
		|| (lens_q > cut_projection_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_threshold_q <= RST_STATIC_THRESHOLD;
			cut_position_q <= RST_CUT_POSITION;
			cut_angle_q <= RST_CUT_ANGLE;
			cut_projection_q <= RST_CUT_PROJECTION;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STATIC_THRESHOLD: static_threshold_q <= cfg_data;
				CFG_CUT_POSITION:     cut_position_q <= cfg_data;
				CFG_CUT_ANGLE:        cut_angle_q <= cfg_data;
				CFG_CUT_PROJECTION:   cut_projection_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			phase_q <= 1'b0;
			cnt_q <= '0;
			prev_valid_q <= 1'b0;
			prev_mode_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q <= '0;
						phase_q <= 1'b0;
						state_q <= measure ? S_DIFF : S_DONE;
					end
				end
				S_DIFF: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (idx_q == IX_EXTENT) begin
							idx_q <= '0;
							state_q <= S_SQ;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SQ: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (idx_q == IX_POS_Z) begin
							cnt_q <= SQRT_LAST;
							state_q <= S_SQRT;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						cnt_q <= MOD_LAST;
						idx_q <= IX_YAW;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						phase_q <= 1'b0;
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (!fold_leave) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (idx_q == IX_YAW) begin
							idx_q <= IX_ROLL;
							cnt_q <= MOD_LAST;
							state_q <= S_MOD;
						end else begin
							cnt_q <= MX_YAW;
							state_q <= S_MAX;
						end
					end
				end
				S_MAX: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MX_LENS) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, is_cut, is_moving,
							is_static, largest_q, mc_q, lens_q, turn_q, move_q};
						m_tuser_q <= ok_q;
						prev_valid_q <= in_ok_q;
						prev_mode_q <= in_mode_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					for (int i = 0; i < NUM_VALUES; i++) begin
						in_q[i] <= s_axis_tdata[i*WORD_W +: WORD_W];
					end
					in_mode_q <= s_axis_tuser[TU_MODE];
					in_ok_q <= s_axis_tuser[TU_OK];
					ok_q <= measure;
					mc_q <= 1'b0;
					move_q <= '0;
					turn_q <= '0;
					lens_q <= '0;
					largest_q <= '0;
				end
			end
			S_DIFF: begin
				if (!phase_q) begin
					acc_q <= alu_rsp.sum;
				end else begin
					diff_q[idx_q] <= alu_rsp.sum[WORD_W-1:0];
					if (idx_q == IX_EXTENT) begin
						acc_q <= '0;
					end
				end
			end
			S_SQ: begin
				if (!phase_q) begin
					prod_s1 <= {{WORD_W{1'b0}}, sq_in} * {{WORD_W{1'b0}}, sq_in};
				end else begin
					acc_q <= alu_rsp.sum;
					if (idx_q == IX_POS_Z) begin
						sat_q <= |alu_rsp.sum[ACC_W-1:2*WORD_W];
						res_q <= '0;
						bit_q <= SQRT_BIT_START;
					end
				end
			end
			S_SQRT: begin
				if (!alu_rsp.neg) begin
					acc_q <= alu_rsp.sum;
				end
				res_q <= res_nxt;
				bit_q <= bit_q >> 2;
				if (cnt_q == '0) begin
					move_q <= sat_q ? '1 : res_nxt[WORD_W-1:0];
					acc_q <= {{PAD_W{1'b0}}, diff_q[IX_YAW]};
					div_q <= DIV_START;
				end
			end
			S_MOD: begin
				if (!alu_rsp.neg) begin
					acc_q <= alu_rsp.sum;
				end
				div_q <= div_q >> 1;
			end
			S_FOLD: begin
				if (fold_leave) begin
					diff_q[idx_q] <= phase_q ? alu_rsp.sum[WORD_W-1:0] : acc_q[WORD_W-1:0];
					if (idx_q == IX_YAW) begin
						acc_q <= {{PAD_W{1'b0}}, diff_q[IX_ROLL]};
						div_q <= DIV_START;
					end
				end
			end
			S_MAX: begin
				run_q <= run_nxt;
				if (cnt_q == MX_ROLL) begin
					turn_q <= run_nxt;
				end
				if (cnt_q == MX_EXTENT) begin
					lens_q <= run_nxt;
				end
				if (cnt_q == MX_LENS) begin
					largest_q <= run_nxt;
					mc_q <= (in_mode_q != prev_mode_q);
				end
			end
			S_DONE: begin
				if (slot_free) begin
					for (int i = 0; i < NUM_VALUES; i++) begin
						prev_q[i] <= in_q[i];
					end
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/cmc_checker.sv
module cmc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [cmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input logic                              m_axis_tuser
);
	import cmc_pkg::*;

	logic [WORD_W-1:0] move_w;
	logic [WORD_W-1:0] turn_w;
	logic [WORD_W-1:0] lens_w;
	logic [WORD_W-1:0] largest_w;
	logic mc_w;
	logic static_w;
	logic moving_w;
	logic cut_w;

	assign move_w = m_axis_tdata[WORD_W-1:0];
	assign turn_w = m_axis_tdata[2*WORD_W-1:WORD_W];
	assign lens_w = m_axis_tdata[3*WORD_W-1:2*WORD_W];
	assign mc_w = m_axis_tdata[3*WORD_W];
	assign largest_w = m_axis_tdata[4*WORD_W:3*WORD_W+1];
	assign static_w = m_axis_tdata[4*WORD_W+1];
	assign moving_w = m_axis_tdata[4*WORD_W+2];
	assign cut_w = m_axis_tdata[4*WORD_W+3];

	// The block works on one camera at a time, so it is busy after every input transaction.
	a_busy_after_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a camera is still being processed");

	a_no_measurement: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> move_w == '0 && turn_w == '0 && lens_w == '0
			&& largest_w == '0 && !mc_w && static_w && !moving_w && !cut_w)
		else $error("result without a measurement carries non-zero deltas or flags");

	a_largest: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> largest_w >= move_w && largest_w >= turn_w && largest_w >= lens_w
			&& (largest_w == move_w || largest_w == turn_w || largest_w == lens_w))
		else $error("largest delta is not the maximum of the three deltas");

	a_mode_cut: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mc_w |-> cut_w && !static_w)
		else $error("projection mode change not classified as a cut");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled output transaction changed");

endmodule

bind camera_motion_classifier cmc_checker u_cmc_checker (.*);

FILE: bench/tb_camera_motion_classifier.sv
`timescale 1ns / 100ps

module tb_camera_motion_classifier;
	import cmc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 120;
	localparam int MAX_IDLE = 17;
	localparam int HOLD_CYCLES = 600;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS = 200;

	localparam logic [63:0] PI_FRAC48 = 64'h0003_243F_6A88_85A3;
	localparam logic [63:0] HALF_ULP = 64'd1 << (47 - FRAC_BITS);
	localparam logic [WORD_W-1:0] HALF_TURN = WORD_W'((PI_FRAC48 + HALF_ULP) >> (48 - FRAC_BITS));
	localparam logic [WORD_W-1:0] FULL_TURN =
		WORD_W'(((PI_FRAC48 << 1) + HALF_ULP) >> (48 - FRAC_BITS));

	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_FIRST = CFG_INDEX_W'(4);
	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LAST = '1;

	typedef enum int {
		STEP_NONE,
		STEP_TINY,
		STEP_SMALL,
		STEP_LARGE,
		STEP_WILD
	} step_t;

	typedef struct packed {
		logic [WORD_W-1:0] extent;
		logic [WORD_W-1:0] aspect;
		logic [WORD_W-1:0] far_dist;
		logic [WORD_W-1:0] near_dist;
		logic [WORD_W-1:0] roll;
		logic [WORD_W-1:0] pitch;
		logic [WORD_W-1:0] yaw;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_x;
	} pose_t;

	typedef struct packed {
		logic valid;
		logic ortho;
		pose_t pose;
	} camera_t;

	typedef struct packed {
		logic cut;
		logic moving;
		logic still;
		logic [WORD_W-1:0] largest;
		logic mode_changed;
		logic [WORD_W-1:0] lens;
		logic [WORD_W-1:0] turn;
		logic [WORD_W-1:0] move;
	} motion_fields_t;

	typedef struct packed {
		logic ok;
		motion_fields_t f;
	} motion_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic [IN_USER_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_data;

	logic [WORD_W-1:0] still_limit;
	logic [WORD_W-1:0] cut_move_limit;
	logic [WORD_W-1:0] cut_turn_limit;
	logic [WORD_W-1:0] cut_lens_limit;
	camera_t last_camera;
	logic last_present;

	motion_t pending_motion[$];
	int fault_count = 0;
	int cycle_count = 0;
	logic source_idle_en = 1'b1;
	logic sink_idle_en = 1'b1;
	int stall_len = 0;
	int stall_reqs = 0;
	int stall_seen = 0;
	int sink_wait = 0;

	camera_motion_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [WORD_W-1:0] span(input logic [WORD_W-1:0] now_v,
			input logic [WORD_W-1:0] was_v);
		longint d;
		d = longint'($signed(now_v)) - longint'($signed(was_v));
		return WORD_W'(d < 0 ? -d : d);
	endfunction

	function automatic logic [WORD_W-1:0] root_floor(input logic [63:0] v);
		logic [WORD_W-1:0] r;
		logic [WORD_W-1:0] trial;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			trial = r | (WORD_W'(1) << i);
			if (64'(trial) * 64'(trial) <= v)
				r = trial;
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] wrap_turn(input logic [WORD_W-1:0] mag);
		logic [WORD_W-1:0] m;
		m = mag % FULL_TURN;
		if (m > HALF_TURN)
			m = FULL_TURN - m;
		return m;
	endfunction

	function automatic logic [WORD_W-1:0] larger(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	task automatic predict_motion(input camera_t cam, output motion_t res);
		logic [65:0] energy;
		logic [WORD_W-1:0] dx;
		logic [WORD_W-1:0] dy;
		logic [WORD_W-1:0] dz;
		res = '0;
		if (last_present && cam.valid) begin
			dx = span(cam.pose.pos_x, last_camera.pose.pos_x);
			dy = span(cam.pose.pos_y, last_camera.pose.pos_y);
			dz = span(cam.pose.pos_z, last_camera.pose.pos_z);
			energy = 66'(64'(dx) * 64'(dx)) + 66'(64'(dy) * 64'(dy)) + 66'(64'(dz) * 64'(dz));
			res.f.move = (energy[65:64] != 2'b00) ? '1 : root_floor(energy[63:0]);
			res.f.turn = larger(wrap_turn(span(cam.pose.yaw, last_camera.pose.yaw)),
				larger(span(cam.pose.pitch, last_camera.pose.pitch),
				wrap_turn(span(cam.pose.roll, last_camera.pose.roll))));
			res.f.lens = larger(span(cam.pose.near_dist, last_camera.pose.near_dist),
				larger(span(cam.pose.far_dist, last_camera.pose.far_dist),
				span(cam.pose.aspect, last_camera.pose.aspect)));
			if (cam.ortho == last_camera.ortho)
				res.f.lens = larger(res.f.lens, span(cam.pose.extent, last_camera.pose.extent));
			res.f.mode_changed = (cam.ortho != last_camera.ortho);
			res.f.largest = larger(res.f.move, larger(res.f.turn, res.f.lens));
			res.ok = 1'b1;
		end
		res.f.still = !res.f.mode_changed && res.f.move <= still_limit &&
			res.f.turn <= still_limit && res.f.lens <= still_limit;
		res.f.moving = res.f.move > still_limit || res.f.turn > still_limit;
		res.f.cut = res.f.mode_changed || res.f.move > cut_move_limit ||
			res.f.turn > cut_turn_limit || res.f.lens > cut_lens_limit;
		last_camera = cam;
		last_present = cam.valid;
	endtask

	task automatic send_camera(input camera_t cam);
		int gap;
		logic [IN_USER_W-1:0] user;
		motion_t res;
		gap = source_idle_en ? $urandom_range(MAX_IDLE, 0) : 0;
		user = '0;
		user[TU_MODE] = cam.ortho;
		user[TU_OK] = cam.valid;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'(cam.pose);
		s_axis_tuser <= user;
		do @(posedge clk); while (!s_axis_tready);
		predict_motion(cam, res);
		pending_motion.push_back(res);
	endtask

	task automatic await_motion_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_motion.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [WORD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_STATIC_THRESHOLD: still_limit = value;
			CFG_CUT_POSITION: cut_move_limit = value;
			CFG_CUT_ANGLE: cut_turn_limit = value;
			CFG_CUT_PROJECTION: cut_lens_limit = value;
			default: ;
		endcase
	endtask

	task automatic program_registers(input logic [WORD_W-1:0] still_v,
			input logic [WORD_W-1:0] move_v, input logic [WORD_W-1:0] turn_v,
			input logic [WORD_W-1:0] lens_v);
		await_motion_drain();
		write_register(CFG_STATIC_THRESHOLD, still_v);
		write_register(CFG_CUT_POSITION, move_v);
		write_register(CFG_CUT_ANGLE, turn_v);
		write_register(CFG_CUT_PROJECTION, lens_v);
		cfg_valid <= 1'b0;
	endtask

	function automatic step_t draw_step();
		int unsigned roll;
		roll = $urandom_range(9, 0);
		if (roll < 3)
			return STEP_NONE;
		if (roll < 6)
			return STEP_TINY;
		if (roll < 8)
			return STEP_SMALL;
		if (roll < 9)
			return STEP_LARGE;
		return STEP_WILD;
	endfunction

	function automatic logic [WORD_W-1:0] nudge(input step_t step);
		case (step)
			STEP_NONE: return '0;
			STEP_TINY: return WORD_W'($urandom_range(64, 0)) - WORD_W'(32);
			STEP_SMALL: return WORD_W'($urandom_range(32'h0001_0000, 0)) - WORD_W'(32'h8000);
			STEP_LARGE: return WORD_W'($urandom_range(32'h0040_0000, 0)) - WORD_W'(32'h20_0000);
			default: return $urandom;
		endcase
	endfunction

	// Most cameras follow on from the previous one so that the flags see every mix of
	// small and large changes; a few are pure noise.
	task automatic next_camera(output camera_t cam);
		step_t pos_step;
		step_t turn_step;
		step_t lens_step;
		cam = last_camera;
		if ($urandom_range(99, 0) < 8) begin
			cam.pose = {$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom};
			cam.ortho = 1'($urandom_range(1, 0));
			cam.valid = 1'($urandom_range(1, 0));
		end else begin
			pos_step = draw_step();
			turn_step = draw_step();
			lens_step = draw_step();
			cam.pose.pos_x = cam.pose.pos_x + nudge(pos_step);
			cam.pose.pos_y = cam.pose.pos_y + nudge(pos_step);
			cam.pose.pos_z = cam.pose.pos_z + nudge(pos_step);
			cam.pose.yaw = cam.pose.yaw + nudge(turn_step);
			cam.pose.pitch = cam.pose.pitch + nudge(turn_step);
			cam.pose.roll = cam.pose.roll + nudge(turn_step);
			cam.pose.near_dist = cam.pose.near_dist + nudge(lens_step);
			cam.pose.far_dist = cam.pose.far_dist + nudge(lens_step);
			cam.pose.aspect = cam.pose.aspect + nudge(lens_step);
			cam.pose.extent = cam.pose.extent + nudge(lens_step);
			if ($urandom_range(99, 0) < 10)
				cam.ortho = ~cam.ortho;
			cam.valid = ($urandom_range(99, 0) >= 6);
		end
	endtask

	task automatic send_random_cameras(input int count);
		camera_t cam;
		repeat (count) begin
			next_camera(cam);
			send_camera(cam);
		end
	endtask

	task automatic compare_field(input string name, input logic [WORD_W-1:0] want_v,
			input logic [WORD_W-1:0] seen_v);
		if (want_v !== seen_v) begin
			if (fault_count < REPORT_LIMIT)
				$display("mismatch in %s: expected %h, got %h", name, want_v, seen_v);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin : sink_pace
		int pause;
		if (stall_reqs != stall_seen) begin
			stall_seen <= stall_reqs;
			sink_wait <= stall_len;
			m_axis_tready <= 1'b0;
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			pause = sink_idle_en ? $urandom_range(MAX_IDLE, 0) : 0;
			if (pause != 0) begin
				sink_wait <= pause - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : motion_check
		motion_t seen;
		motion_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.ok = m_axis_tuser;
			seen.f = m_axis_tdata[OUT_FIELDS_W-1:0];
			if (pending_motion.size() == 0) begin
				if (fault_count < REPORT_LIMIT)
					$display("result with no camera pending: ok %b data %h", seen.ok, m_axis_tdata);
				fault_count++;
			end else begin
				want = pending_motion.pop_front();
				compare_field("ok", WORD_W'(want.ok), WORD_W'(seen.ok));
				compare_field("move_delta", want.f.move, seen.f.move);
				compare_field("turn_delta", want.f.turn, seen.f.turn);
				compare_field("lens_delta", want.f.lens, seen.f.lens);
				compare_field("mode_changed", WORD_W'(want.f.mode_changed),
					WORD_W'(seen.f.mode_changed));
				compare_field("largest_delta", want.f.largest, seen.f.largest);
				compare_field("is_static", WORD_W'(want.f.still), WORD_W'(seen.f.still));
				compare_field("is_moving", WORD_W'(want.f.moving), WORD_W'(seen.f.moving));
				compare_field("is_cut", WORD_W'(want.f.cut), WORD_W'(seen.f.cut));
			end
		end
	end

	task automatic test_directed_defaults();
		camera_t cam;
		cam = '0;
		cam.valid = 1'b1;
		send_camera(cam);
		send_camera(cam);
		cam.pose.pos_x = 32'h0000_C001;
		send_camera(cam);
		cam.pose.pos_x = 32'h7FFF_FFFF;
		cam.pose.pos_y = 32'h7FFF_FFFF;
		cam.pose.pos_z = 32'h7FFF_FFFF;
		send_camera(cam);
		// The full-range jump on all three axes overflows the sum of squares.
		cam.pose.pos_x = 32'h8000_0000;
		cam.pose.pos_y = 32'h8000_0000;
		cam.pose.pos_z = 32'h8000_0000;
		send_camera(cam);
		cam.pose.pos_x = '0;
		cam.pose.pos_y = '0;
		cam.pose.pos_z = '0;
		send_camera(cam);
		cam.pose.yaw = HALF_TURN;
		send_camera(cam);
		cam.pose.yaw = cam.pose.yaw + HALF_TURN + 32'd1;
		send_camera(cam);
		cam.pose.yaw = cam.pose.yaw + 32'd5 * FULL_TURN;
		send_camera(cam);
		cam.pose.yaw = 32'h8000_0000;
		send_camera(cam);
		cam.pose.yaw = 32'h7FFF_FFFF;
		send_camera(cam);
		cam.pose.roll = -(32'd3 * FULL_TURN + 32'd5);
		send_camera(cam);
		cam.pose.roll = 32'h7FFF_FFFF;
		send_camera(cam);
		cam.pose.pitch = 32'h8000_0000;
		send_camera(cam);
		cam.pose.pitch = 32'h7FFF_FFFF;
		send_camera(cam);
		cam.pose.near_dist = 32'h8000_0000;
		cam.pose.far_dist = 32'h7FFF_FFFF;
		cam.pose.aspect = 32'h0001_0000;
		send_camera(cam);
		cam.pose.extent = 32'h0040_0000;
		send_camera(cam);
		// A change of projection mode leaves the extent out of the lens delta.
		cam.ortho = 1'b1;
		cam.pose.extent = '0;
		send_camera(cam);
		send_camera(cam);
		cam.valid = 1'b0;
		send_camera(cam);
		cam.valid = 1'b1;
		send_camera(cam);
		cam.pose.pos_y = cam.pose.pos_y + 32'd100;
		send_camera(cam);
	endtask

	task automatic test_unmapped_registers();
		camera_t cam;
		await_motion_drain();
		write_register(CFG_UNMAPPED_FIRST, '1);
		write_register(CFG_UNMAPPED_LAST, '1);
		cfg_valid <= 1'b0;
		cam = last_camera;
		cam.pose.pos_x = cam.pose.pos_x + 32'h0001_0000;
		send_camera(cam);
		cam.pose.aspect = cam.pose.aspect + 32'h0000_4000;
		send_camera(cam);
	endtask

	task automatic test_threshold_extremes();
		program_registers('0, '0, '0, '0);
		send_random_cameras(8);
		program_registers('1, '1, '1, '1);
		send_random_cameras(8);
	endtask

	task automatic test_output_backpressure();
		await_motion_drain();
		source_idle_en = 1'b0;
		stall_len <= HOLD_CYCLES;
		stall_reqs <= stall_reqs + 1;
		send_random_cameras(30);
		source_idle_en = 1'b1;
	endtask

	task automatic test_random_motion();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: program_registers(32'd0, 32'd49152, 32'd22938, 32'd13107);
				3: program_registers('1, '0, '1, '0);
				default: program_registers($urandom_range(32'h0002_0000, 0),
					$urandom_range(32'h0010_0000, 0), $urandom_range(32'h0010_0000, 0),
					$urandom_range(32'h0010_0000, 0));
			endcase
			if (phase == 1) begin
				source_idle_en = 1'b0;
				sink_idle_en <= 1'b0;
			end else if (phase == 2) begin
				source_idle_en = 1'b1;
				sink_idle_en <= 1'b1;
			end else begin
				source_idle_en = 1'($urandom_range(1, 0));
				sink_idle_en <= 1'($urandom_range(1, 0));
			end
			send_random_cameras(PHASE_ITEMS / 2);
			if (phase == 2)
				await_motion_drain();
			send_random_cameras(PHASE_ITEMS / 2);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		still_limit = 32'd0;
		cut_move_limit = 32'd49152;
		cut_turn_limit = 32'd22938;
		cut_lens_limit = 32'd13107;
		last_camera = '0;
		last_present = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_unmapped_registers();
		test_threshold_extremes();
		test_output_backpressure();
		test_random_motion();
		await_motion_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		fault_count += pending_motion.size();
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: camera_motion_classifier.f
hw/rtl/cmc_pkg.sv
hw/rtl/cmc_addsub.sv
hw/rtl/camera_motion_classifier.sv
hw/rtl/cmc_checker.sv
bench/tb_camera_motion_classifier.sv
